@@ rtl/mie_pkg.sv @@
// shared types and constants for the modular inverse block
// no dependencies; used by mie_ctrl, mie_datapath and the top level
package mie_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);

   typedef logic [WIDTH-1:0] word_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam word_type MOD_RESET = word_type'(100000007);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ALIGN  = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   // sequencer to datapath
   typedef struct packed {
      logic load;
      logic align;
      logic div;
      logic update;
      logic finish;
   } dp_ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic small_mod;
      logic can_shift;
      logic cnt_zero;
      logic rem_zero;
   } dp_stat_type;

endpackage

@@ rtl/mie_datapath.sv @@
// datapath of the modular inverse block: euclid remainders, bezout coefficients
// and the shared shift-subtract / modular horner unit; depends on mie_pkg
module mie_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mie_pkg::dp_ctl_type ctl,
   input  mie_pkg::word_type   modulus,
   input  mie_pkg::word_type   value,
   output mie_pkg::dp_stat_type stat,
   output mie_pkg::word_type   inverse,
   output logic                no_inverse
);

   localparam int W = mie_pkg::WIDTH;

   mie_pkg::word_type rem_ff, rem_in;   // running remainder (dividend)
   mie_pkg::word_type dsr_ff, dsr_in;   // divisor as is
   mie_pkg::word_type div_ff, div_in;   // divisor shifted into place
   mie_pkg::word_type t0_ff, t0_in;
   mie_pkg::word_type t1_ff, t1_in;
   mie_pkg::word_type acc_ff, acc_in;   // quotient * t1 mod m, built msb first
   mie_pkg::cnt_type  cnt_ff, cnt_in;

   logic            qbit;
   mie_pkg::word_type div_shl;
   logic [W+1:0]    hsum, hsub1, hsub2, mod_x1, mod_x2;
   mie_pkg::word_type acc_next;
   logic [W:0]      tdiff;
   mie_pkg::word_type t2;

   // one quotient bit per cycle
   assign qbit    = (rem_ff >= div_ff);
   assign div_shl = {div_ff[W-2:0], 1'b0};

   // acc = 2*acc + qbit*t1, reduced below m (sum stays under 3m)
   assign mod_x1 = {2'b00, modulus};
   assign mod_x2 = {1'b0, modulus, 1'b0};
   assign hsum   = {1'b0, acc_ff, 1'b0} + {2'b00, (qbit ? t1_ff : '0)};
   assign hsub1  = hsum - mod_x1;
   assign hsub2  = hsum - mod_x2;

   always_comb begin
      priority if (hsum >= mod_x2) begin
         acc_next = hsub2[W-1:0];
      end else if (hsum >= mod_x1) begin
         acc_next = hsub1[W-1:0];
      end else begin
         acc_next = hsum[W-1:0];
      end
   end

   // t2 = t0 - q*t1 mod m
   assign tdiff = {1'b0, t0_ff} - {1'b0, acc_ff};
   assign t2    = tdiff[W] ? (tdiff[W-1:0] + modulus) : tdiff[W-1:0];

   assign stat.small_mod = (modulus < mie_pkg::word_type'(2));
   assign stat.can_shift = !div_ff[W-1] && (div_shl <= rem_ff);
   assign stat.cnt_zero  = (cnt_ff == '0);
   assign stat.rem_zero  = (rem_ff == '0);

   always_comb begin
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      div_in = div_ff;
      t0_in  = t0_ff;
      t1_in  = t1_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      priority if (ctl.load) begin
         // euclid on (value, m) with coefficients (1, 0) reduces value first
         rem_in = stat.small_mod ? '0 : value;
         dsr_in = modulus;
         div_in = modulus;
         t0_in  = mie_pkg::word_type'(1);
         t1_in  = '0;
         acc_in = '0;
         cnt_in = '0;
      end else if (ctl.align) begin
         if (stat.can_shift) begin
            div_in = div_shl;
            cnt_in = cnt_ff + mie_pkg::cnt_type'(1);
         end
      end else if (ctl.div) begin
         rem_in = qbit ? (rem_ff - div_ff) : rem_ff;
         div_in = {1'b0, div_ff[W-1:1]};
         acc_in = acc_next;
         if (!stat.cnt_zero) begin
            cnt_in = cnt_ff - mie_pkg::cnt_type'(1);
         end
      end else if (ctl.update) begin
         // (r0, r1) <- (r1, r0 mod r1), same for the coefficients
         rem_in = dsr_ff;
         dsr_in = rem_ff;
         div_in = rem_ff;
         t0_in  = t1_ff;
         t1_in  = t2;
         acc_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      div_ff <= div_in;
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      acc_ff <= acc_in;
   end

   // at the end rem holds the gcd and t0 its coefficient
   assign no_inverse = (rem_ff != mie_pkg::word_type'(1));
   assign inverse    = no_inverse ? '0 : t0_ff;

endmodule

@@ rtl/mie_ctrl.sv @@
// sequencer of the modular inverse block: align, divide and update per euclid step
// depends on mie_pkg
module mie_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 out_free,
   input  mie_pkg::dp_stat_type stat,
   output mie_pkg::dp_ctl_type  ctl
);

   mie_pkg::state_type state_ff, state_in;

   assign req_ready = (state_ff == mie_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         mie_pkg::ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = stat.small_mod ? mie_pkg::ST_DONE : mie_pkg::ST_ALIGN;
            end
         end
         mie_pkg::ST_ALIGN: begin
            ctl.align = 1'b1;
            if (!stat.can_shift) begin
               state_in = mie_pkg::ST_DIV;
            end
         end
         mie_pkg::ST_DIV: begin
            ctl.div = 1'b1;
            if (stat.cnt_zero) begin
               state_in = mie_pkg::ST_UPDATE;
            end
         end
         mie_pkg::ST_UPDATE: begin
            ctl.update = 1'b1;
            // remainder of zero ends the euclid loop
            state_in = stat.rem_zero ? mie_pkg::ST_DONE : mie_pkg::ST_ALIGN;
         end
         mie_pkg::ST_DONE: begin
            if (out_free) begin
               ctl.finish = 1'b1;
               state_in   = mie_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mie_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mie_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/modular_inverse_ext_euclid.sv @@
// Modular inverse by the extended Euclidean algorithm. Each word on req_value is
// inverted modulo the csr_modulus register (reset 100000007) and answered on rsp_ with
// the inverse in 0 .. modulus-1; when none exists (value zero, a common factor, or a
// modulus below two) rsp_inverse is 0 and rsp_no_inverse is 1. One word is worked at a
// time on a single shift-subtract unit: per Euclid quotient the divisor is aligned,
// the quotient bits are found msb first and the coefficients are updated. A first
// step of the same kind reduces the value below the modulus; taking the word and
// handing off the result are states of their own. A modulus below two goes from
// taking the word straight to handing off the result. The result sits in an output
// register, so the next word is taken while it waits. The user is to write the
// modulus only while no word is in flight; the block itself does not enforce this.
// depends on mie_pkg, mie_ctrl and mie_datapath
module modular_inverse_ext_euclid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mie_pkg::word_type    req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mie_pkg::word_type    rsp_inverse,
   output logic                 rsp_no_inverse,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  mie_pkg::word_type    csr_modulus
);

   mie_pkg::word_type    modulus_ff, modulus_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mie_pkg::word_type    rsp_inverse_ff, rsp_inverse_in;
   logic                 rsp_no_inverse_ff, rsp_no_inverse_in;

   mie_pkg::dp_ctl_type  ctl;
   mie_pkg::dp_stat_type stat;
   mie_pkg::word_type    dp_inverse;
   logic                 dp_no_inverse;
   logic                 out_free;

   assign csr_ready  = 1'b1;
   assign modulus_in = (csr_valid && csr_ready) ? csr_modulus : modulus_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   mie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .stat      (stat),
      .ctl       (ctl)
   );

   mie_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .modulus    (modulus_ff),
      .value      (req_value),
      .stat       (stat),
      .inverse    (dp_inverse),
      .no_inverse (dp_no_inverse)
   );

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_inverse_in    = rsp_inverse_ff;
      rsp_no_inverse_in = rsp_no_inverse_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.finish) begin
         rsp_valid_in      = 1'b1;
         rsp_inverse_in    = dp_inverse;
         rsp_no_inverse_in = dp_no_inverse;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= mie_pkg::MOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_inverse_ff    <= rsp_inverse_in;
      rsp_no_inverse_ff <= rsp_no_inverse_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inverse    = rsp_inverse_ff;
   assign rsp_no_inverse = rsp_no_inverse_ff;

   // a taken word keeps the block busy for the next cycle at least
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a word was taken");

   // the flag and the inverse value agree
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_inverse |-> rsp_inverse == '0)
      else $error("nonzero inverse with no_inverse set");

   a_inverse_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_no_inverse |-> rsp_inverse != '0)
      else $error("zero inverse reported as valid");

endmodule
